FILE: rtl/sqi_pkg.sv
// constants, types and the quarter-wave sine table for the sine table core
`default_nettype none

package sqi_pkg;

    localparam int PHASE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int TABLE_STEPS   = 90;

    localparam int OUT_BITS   = OUT_FRAC_BITS + 2;
    localparam int QTR_SHIFT  = PHASE_BITS - 2;
    localparam int A_BITS     = QTR_SHIFT + 1;
    localparam int IDX_BITS   = $clog2(TABLE_STEPS + 1);
    localparam int POS_BITS   = A_BITS + IDX_BITS;
    localparam int MAG_BITS   = OUT_FRAC_BITS + 1;
    localparam int PROD_BITS  = MAG_BITS + QTR_SHIFT + 1;
    localparam int ROUND_SH   = 30 - OUT_FRAC_BITS;

    localparam logic [MAG_BITS-1:0]   ONE      = MAG_BITS'(1) << OUT_FRAC_BITS;
    localparam logic [PHASE_BITS-1:0] HALF_TURN = PHASE_BITS'(1) << (PHASE_BITS - 1);
    localparam logic [PROD_BITS-1:0]  HALF_LSB = PROD_BITS'(1) << (QTR_SHIFT - 1);

    // pi/2 in Q62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    // taylor divisors (2n)(2n+1)
    localparam logic [63:0] TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic [MAG_BITS-1:0] rom_t [0:TABLE_STEPS];

    // sin(k*(pi/2)/TABLE_STEPS) per entry, q30 taylor series, rounded half up
    function automatic rom_t build_sine_rom();
        rom_t               rom;
        logic [63:0]        hp50;
        logic [63:0]        x50;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        term;
        logic signed [63:0] sum;
        hp50 = HALF_PI_Q62 >> 12;
        for (int k = 0; k <= TABLE_STEPS; k++) begin
            if (k == 0) begin
                rom[k] = '0;
            end
            else if (k >= TABLE_STEPS) begin
                rom[k] = ONE;
            end
            else begin
                x50  = (64'(k) * hp50) / 64'(TABLE_STEPS);
                x    = (x50 + (64'd1 << 19)) >> 20;
                x2   = (x * x + (64'd1 << 29)) >> 30;
                term = x;
                sum  = signed'(x);
                for (int n = 1; n <= 12; n++) begin
                    if (term != 64'd0) begin
                        t    = (term * x2 + (64'd1 << 29)) >> 30;
                        term = t / TAYLOR_DIV[n];
                        if ((n % 2) == 1)
                            sum = sum - signed'(term);
                        else
                            sum = sum + signed'(term);
                    end
                end
                if (sum < 0)
                    sum = 0;
                if (ROUND_SH > 0)
                    sum = signed'((unsigned'(sum) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH);
                if (sum > signed'(64'(ONE)))
                    sum = signed'(64'(ONE));
                rom[k] = sum[MAG_BITS-1:0];
            end
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: rtl/sqi_phase_if.sv
// valid/ready channel that carries one phase beat
`default_nettype none

interface sqi_phase_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sqi_pkg::PHASE_BITS-1:0]  phase;

    modport source (output valid, output phase, input ready);
    modport sink   (input valid, input phase, output ready);
endinterface

`default_nettype wire

FILE: rtl/sqi_sine_if.sv
// valid/ready channel that carries one sine beat
`default_nettype none

interface sqi_sine_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sqi_pkg::OUT_BITS-1:0]  sine;

    modport source (output valid, output sine, input ready);
    modport sink   (input valid, input sine, output ready);
endinterface

`default_nettype wire

FILE: rtl/sine_quarter_table_interp_core.sv
// five-stage pipelined sine from a quarter-wave table with linear interpolation
//
//  channel    dir  payload            meaning
//  phase_ch   in   phase  s16         angle, 65536 per turn
//  sine_ch    out  sine   s16 (q2.14) sine of the angle, 16384 = 1.0
//
// one beat per clock while the output is not stalled
// stages: fold, scale to table steps, table read, interp multiply, add and sign
// each stage holds its beat only while the next one is full and stalled, so
// bubbles close up; the input moves while a result waits and a stage is empty
// rst_n clears the stage valid bits only; the data registers are not reset
`default_nettype none

module sine_quarter_table_interp_core (
    input  wire          clk,
    input  wire          rst_n,
    sqi_phase_if.sink    phase_ch,
    sqi_sine_if.source   sine_ch
);

    localparam int PB = sqi_pkg::PHASE_BITS;
    localparam int AB = sqi_pkg::A_BITS;
    localparam int PS = sqi_pkg::POS_BITS;
    localparam int IB = sqi_pkg::IDX_BITS;
    localparam int MB = sqi_pkg::MAG_BITS;
    localparam int QS = sqi_pkg::QTR_SHIFT;
    localparam int RB = sqi_pkg::PROD_BITS;
    localparam int OB = sqi_pkg::OUT_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // stage 1: sign and fold into the first quarter
    logic          neg1_reg;
    logic [AB-1:0] a1_reg;
    logic          neg1_next;
    logic [PB-1:0] abs1;
    logic [PB-1:0] fold1;
    logic [AB-1:0] a1_next;

    // stage 2: position in table steps
    logic          neg2_reg;
    logic [PS-1:0] pos2_reg;
    logic [PS-1:0] pos2_next;

    // stage 3: neighbouring entries
    logic          neg3_reg;
    logic          down3_reg;
    logic [MB-1:0] lo3_reg;
    logic [MB-1:0] diff3_reg;
    logic [QS-1:0] frac3_reg;
    logic [PS-QS-1:0] idx_full;
    logic          top3;
    logic [IB-1:0] lo_idx;
    logic [IB-1:0] hi_idx;
    logic [MB-1:0] lo_val;
    logic [MB-1:0] hi_val;
    logic          down3_next;
    logic [MB-1:0] lo3_next;
    logic [MB-1:0] diff3_next;

    // stage 4: interpolation product
    logic          neg4_reg;
    logic          down4_reg;
    logic [MB-1:0] lo4_reg;
    logic [RB-1:0] prod4_reg;
    logic [RB-1:0] prod4_next;

    // stage 5: output register
    logic signed [OB-1:0] sine5_reg;
    logic signed [OB-1:0] sine5_next;
    logic [MB-1:0]        r5;
    logic [MB-1:0]        val5;

    assign en5 = !v5_reg || sine_ch.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign phase_ch.ready = en1;
    assign sine_ch.valid  = v5_reg;
    assign sine_ch.sine   = sine5_reg;

    always_comb
    begin
        neg1_next = phase_ch.phase[PB-1];
        abs1      = neg1_next ? (~phase_ch.phase + PB'(1)) : phase_ch.phase;
        // past a quarter turn: half turn minus magnitude
        fold1     = abs1;
        if (abs1 > (PB'(1) << QS))
            fold1 = sqi_pkg::HALF_TURN - abs1;
        a1_next   = fold1[AB-1:0];
    end

    assign pos2_next = PS'(a1_reg) * PS'(sqi_pkg::TABLE_STEPS);

    always_comb
    begin
        idx_full = pos2_reg[PS-1:QS];
        top3     = idx_full >= (PS-QS)'(sqi_pkg::TABLE_STEPS);
        lo_idx   = idx_full[IB-1:0];
        hi_idx   = top3 ? lo_idx : lo_idx + IB'(1);
        lo_val   = sqi_pkg::SINE_ROM[lo_idx];
        hi_val   = sqi_pkg::SINE_ROM[hi_idx];
        if (top3)
        begin
            lo3_next   = sqi_pkg::ONE;
            diff3_next = '0;
            down3_next = 1'b0;
        end
        else
        begin
            lo3_next   = lo_val;
            down3_next = hi_val < lo_val;
            diff3_next = down3_next ? (lo_val - hi_val) : (hi_val - lo_val);
        end
    end

    assign prod4_next = RB'(diff3_reg) * RB'(frac3_reg) + sqi_pkg::HALF_LSB;

    always_comb
    begin
        r5         = prod4_reg[QS +: MB];
        val5       = down4_reg ? (lo4_reg - r5) : (lo4_reg + r5);
        sine5_next = neg4_reg ? -signed'(OB'(val5)) : signed'(OB'(val5));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= phase_ch.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            neg1_reg <= neg1_next;
            a1_reg   <= a1_next;
        end
        if (en2)
        begin
            neg2_reg <= neg1_reg;
            pos2_reg <= pos2_next;
        end
        if (en3)
        begin
            neg3_reg  <= neg2_reg;
            down3_reg <= down3_next;
            lo3_reg   <= lo3_next;
            diff3_reg <= diff3_next;
            frac3_reg <= pos2_reg[QS-1:0];
        end
        if (en4)
        begin
            neg4_reg  <= neg3_reg;
            down4_reg <= down3_reg;
            lo4_reg   <= lo3_reg;
            prod4_reg <= prod4_next;
        end
        if (en5)
        begin
            sine5_reg <= sine5_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sqi_checker.sv
// port checks for the sine table core, bound to the top level
`default_nettype none

module sqi_checker (
    input wire                                   clk,
    input wire                                   rst_n,
    input wire                                   in_valid,
    input wire                                   in_ready,
    input wire                                   out_valid,
    input wire                                   out_ready,
    input wire signed [sqi_pkg::OUT_BITS-1:0]    sine
);

    localparam logic signed [sqi_pkg::OUT_BITS-1:0] MAX_SINE =
        signed'(sqi_pkg::OUT_BITS'(sqi_pkg::ONE));

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sine))
        else $error("sine beat changed while stalled");

    // result stays within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sine <= MAX_SINE) && (sine >= -MAX_SINE))
        else $error("sine out of range");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result beat during reset");

    // with no result waiting the pipeline always has room
    a_room: assert property (@(posedge clk)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // handshake lines are never unknown out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid, out_ready}))
        else $error("unknown handshake value");

endmodule

bind sine_quarter_table_interp_core sqi_checker u_sqi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (phase_ch.valid),
    .in_ready  (phase_ch.ready),
    .out_valid (sine_ch.valid),
    .out_ready (sine_ch.ready),
    .sine      (sine_ch.sine)
);

`default_nettype wire
